/* rtl/core/apsearch_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package apsearch_pkg;

   localparam int DATA_WIDTH      = 8;
   localparam int ADDR_WIDTH      = 32;
   localparam int REGION_WIDTH    = 8;
   localparam int ALIGN_WIDTH     = 16;
   localparam int PATTERN_WIDTH   = 64;
   localparam int LENGTH_WIDTH    = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam int PATTERN_MAX_DEFAULT = 8;
   localparam int MAX_REGIONS_DEFAULT = 255;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1,
      CSR_ALIGNMENT      = 2'd2,
      CSR_REGION_COUNT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic commit;
      logic clear;
      logic region_start;
      logic phase_zero;
   } win_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/apsearch_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface apsearch_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [31:0] byte_address;
   logic [7:0]  region_number;
   logic        region_first;
   logic        search_first;
   logic        search_last;

   modport source (output valid, data_byte, byte_address, region_number,
                   region_first, search_first, search_last, input ready);
   modport sink   (input valid, data_byte, byte_address, region_number,
                   region_first, search_first, search_last, output ready);
endinterface

interface apsearch_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_address;
   logic [7:0]  match_region;

   modport source (output valid, found, match_address, match_region, input ready);
   modport sink   (input valid, found, match_address, match_region, output ready);
endinterface

`default_nettype wire

/* rtl/core/apsearch_mod_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle.
module apsearch_mod_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [apsearch_pkg::ADDR_WIDTH-1:0] dividend,
   input  wire logic [apsearch_pkg::ALIGN_WIDTH-1:0] divisor,
   output logic                                     done,
   output logic [apsearch_pkg::ALIGN_WIDTH-1:0]     remainder
);
   import apsearch_pkg::*;

   localparam int CNT_W = $clog2(ADDR_WIDTH);

   logic [ALIGN_WIDTH-1:0] rem_ff, rem_in;
   logic [ADDR_WIDTH-1:0]  quo_ff, quo_in;
   logic [ALIGN_WIDTH-1:0] div_ff, div_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [ALIGN_WIDTH:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[ADDR_WIDTH-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = ALIGN_WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[ALIGN_WIDTH-1:0];
         end
         quo_in = {quo_ff[ADDR_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ADDR_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/core/apsearch_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte window, start-alignment history and region fill count.
module apsearch_window #(
   parameter int PATTERN_MAX = apsearch_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire apsearch_pkg::win_ctrl_type            ctrl,
   input  wire logic [apsearch_pkg::DATA_WIDTH-1:0]   data_byte,
   input  wire logic [PATTERN_MAX*8-1:0]              pattern,
   input  wire logic [$clog2(PATTERN_MAX+1)-1:0]      length,
   output logic                                       hit
);
   import apsearch_pkg::*;

   localparam int CNT_W = $clog2(PATTERN_MAX + 1);
   localparam int WIN_W = PATTERN_MAX * DATA_WIDTH;

   logic [WIN_W-1:0]       win_ff, win_in, win_base;
   logic [PATTERN_MAX-1:0] hist_ff, hist_in, hist_base;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, cnt_base;
   logic                   start_ok;
   logic                   bytes_ok;

   always_comb begin
      win_base  = ctrl.clear ? '0 : win_ff;
      hist_base = ctrl.clear ? '0 : hist_ff;
      cnt_base  = ctrl.region_start ? '0 : cnt_ff;
      win_in    = WIN_W'({win_base, data_byte});
      hist_in   = PATTERN_MAX'({hist_base, ctrl.phase_zero});
      cnt_in    = (cnt_base == CNT_W'(PATTERN_MAX)) ? cnt_base : cnt_base + 1'b1;

      start_ok = 1'b0;
      bytes_ok = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (j == int'(length) - 1) begin
            start_ok = hist_in[j];
         end
         // newest byte sits at lane 0 and holds the last pattern byte
         for (int m = 0; m < PATTERN_MAX; m++) begin
            if (j < int'(length) && m == int'(length) - 1 - j) begin
               if (win_in[j*DATA_WIDTH +: DATA_WIDTH] != pattern[m*8 +: 8]) begin
                  bytes_ok = 1'b0;
               end
            end
         end
      end
      hit = start_ok && bytes_ok && (cnt_in >= length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         hist_ff <= '0;
         cnt_ff  <= '0;
      end else if (ctrl.commit) begin
         win_ff  <= win_in;
         hist_ff <= hist_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/aligned_pattern_search_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Flow: an accepted beat moves to the step state, which registers the result;
// a byte that opens a region or a search first waits in the divide state on the
// bit-serial address-modulo-alignment unit (one address bit per cycle).
// Input is held off until the step of the current byte is done; a result
// that still waits on the result side holds the next result-producing byte.
// Reset: synchronous, active high; registers return to pattern 0, length 1,
// alignment 1, region count 0, and the search state clears.
module aligned_pattern_search_top #(
   parameter int PATTERN_MAX = apsearch_pkg::PATTERN_MAX_DEFAULT,
   parameter int MAX_REGIONS = apsearch_pkg::MAX_REGIONS_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   apsearch_req_if.sink                                  req_bus,
   apsearch_rsp_if.source                                rsp_bus,
   input  wire logic                                     csr_write_enable,
   input  wire logic [apsearch_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [apsearch_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import apsearch_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   // configuration
   logic [PATTERN_WIDTH-1:0] pattern_ff;
   logic [LENGTH_WIDTH-1:0]  length_ff;
   logic [ALIGN_WIDTH-1:0]   align_ff;
   logic [REGION_WIDTH-1:0]  regions_ff;

   // captured beat
   logic [DATA_WIDTH-1:0]   data_ff;
   logic [ADDR_WIDTH-1:0]   addr_ff;
   logic [REGION_WIDTH-1:0] region_ff;
   logic                    rfirst_ff, sfirst_ff, slast_ff;

   state_type state_ff, state_in;
   logic [ALIGN_WIDTH-1:0] phase_ff, phase_in;
   logic                   done_ff, done_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [ADDR_WIDTH-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [REGION_WIDTH-1:0] rsp_region_ff, rsp_region_in;

   logic [ALIGN_WIDTH-1:0]  align_eff;
   logic [LEN_W-1:0]        len_used;
   logic [REGION_WIDTH-1:0] regions_used;
   logic                    req_accept;
   logic                    mod_start, mod_done;
   logic [ALIGN_WIDTH-1:0]  mod_rem;
   logic [ALIGN_WIDTH:0]    phase_inc;
   logic                    region_start;
   logic                    skip;
   logic                    win_hit, match, has_result, rsp_stall;
   win_ctrl_type            win_ctrl;

   assign align_eff = (align_ff == '0) ? ALIGN_WIDTH'(1) : align_ff;

   always_comb begin
      if (length_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (length_ff > LENGTH_WIDTH'(PATTERN_MAX)) begin
         len_used = LEN_W'(PATTERN_MAX);
      end else begin
         len_used = LEN_W'(length_ff);
      end
      regions_used = (regions_ff > REGION_WIDTH'(MAX_REGIONS)) ?
                     REGION_WIDTH'(MAX_REGIONS) : regions_ff;
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign mod_start     = req_accept && (req_bus.region_first || req_bus.search_first);

   apsearch_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_bus.byte_address),
      .divisor   (align_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // step of the captured beat
   always_comb begin
      region_start = rfirst_ff || sfirst_ff;
      skip         = done_ff && !sfirst_ff;
      phase_inc    = {1'b0, phase_ff} + 1'b1;
      if (region_start) begin
         phase_in = mod_rem;
      end else if (phase_inc >= {1'b0, align_eff}) begin
         phase_in = '0;
      end else begin
         phase_in = phase_inc[ALIGN_WIDTH-1:0];
      end
   end

   apsearch_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .data_byte (data_ff),
      .pattern   (pattern_ff[PATTERN_MAX*8-1:0]),
      .length    (len_used),
      .hit       (win_hit)
   );

   assign match      = win_hit && (region_ff < regions_used);
   assign has_result = match || slast_ff;
   assign rsp_stall  = rsp_valid_ff && !rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_region_in = rsp_region_ff;
      win_ctrl.commit       = 1'b0;
      win_ctrl.clear        = sfirst_ff;
      win_ctrl.region_start = region_start;
      win_ctrl.phase_zero   = (phase_in == '0);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = mod_start ? ST_DIVIDE : ST_STEP;
            end
         end
         ST_DIVIDE: begin
            if (mod_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (skip) begin
               state_in = ST_IDLE;
            end else if (!(has_result && rsp_stall)) begin
               // commit the byte; hold while a result still waits
               win_ctrl.commit = 1'b1;
               state_in        = ST_IDLE;
               done_in         = has_result;
               if (has_result) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = match;
                  if (match) begin
                     rsp_addr_in   = addr_ff - ADDR_WIDTH'(len_used) + 1'b1;
                     rsp_region_in = region_ff;
                  end else begin
                     rsp_addr_in   = '0;
                     rsp_region_in = regions_used;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (win_ctrl.commit) begin
            phase_ff <= phase_in;
         end
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_region_ff <= rsp_region_in;
      if (req_accept) begin
         data_ff   <= req_bus.data_byte;
         addr_ff   <= req_bus.byte_address;
         region_ff <= req_bus.region_number;
         rfirst_ff <= req_bus.region_first;
         sfirst_ff <= req_bus.search_first;
         slast_ff  <= req_bus.search_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LENGTH_WIDTH'(1);
         align_ff   <= ALIGN_WIDTH'(1);
         regions_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:  pattern_ff <= csr_write_data[PATTERN_WIDTH-1:0];
            CSR_PATTERN_LENGTH: length_ff  <= csr_write_data[LENGTH_WIDTH-1:0];
            CSR_ALIGNMENT:      align_ff   <= csr_write_data[ALIGN_WIDTH-1:0];
            CSR_REGION_COUNT:   regions_ff <= csr_write_data[REGION_WIDTH-1:0];
            default: begin
               pattern_ff <= pattern_ff;
            end
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.found         = rsp_found_ff;
   assign rsp_bus.match_address = rsp_addr_ff;
   assign rsp_bus.match_region  = rsp_region_ff;

endmodule

`default_nettype wire

/* rtl/core/apsearch_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module apsearch_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_found,
   input wire logic [31:0] rsp_match_address,
   input wire logic [7:0]  rsp_match_region
);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_match_address) && $stable(rsp_match_region))
      else $error("result beat dropped or changed while stalled");

   // one byte at a time: no new beat right after an accepted one
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted back to back");

   // a miss carries a zero address
   a_miss_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_address == 32'd0)
      else $error("miss result with nonzero address");

   // a new result comes out of a step, while input was held off
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a processed byte");

endmodule

bind aligned_pattern_search_top apsearch_checker u_apsearch_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_found         (rsp_bus.found),
   .rsp_match_address (rsp_bus.match_address),
   .rsp_match_region  (rsp_bus.match_region)
);

`default_nettype wire
